/* design/cfdd_pkg.sv */
// ----------------------------------------------------------------------------
// cfdd_pkg: shared types, constants and scaling functions
// Register codes, deadband limits and the pitch scaling used by the
// control frame deframer.
// ----------------------------------------------------------------------------
package cfdd_pkg;

  // Window and field widths
  localparam int unsigned WIN_DEPTH   = 8;
  localparam int unsigned FILL_W      = $clog2(WIN_DEPTH + 1);
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned AXIS_W      = 9;
  localparam int unsigned PITCH_W     = 14;
  localparam int unsigned VERT_W      = 8;
  localparam int unsigned MODE_W      = 2;
  localparam int unsigned CFG_INDEX_W = 1;
  localparam int unsigned CFG_DATA_W  = 8;

  // Register reset values
  localparam logic [BYTE_W-1:0] HEAD_RESET = 8'd170;
  localparam logic [BYTE_W-1:0] TAIL_RESET = 8'd85;

  // Deadband around the stick center
  localparam logic [BYTE_W-1:0] DEAD_LO = 8'd123;
  localparam logic [BYTE_W-1:0] DEAD_HI = 8'd131;
  localparam logic [AXIS_W-1:0] CENTER  = 9'd127;

  // Button bits
  localparam int unsigned BTN_DOWN = 0;
  localparam int unsigned BTN_UP   = 1;
  localparam int unsigned BTN_FAST = 2;
  localparam int unsigned BTN_SLOW = 3;

  // Vertical thrust levels
  localparam logic signed [VERT_W-1:0] VERT_POS  = 8'sd64;
  localparam logic signed [VERT_W-1:0] VERT_NEG  = -8'sd64;
  localparam logic signed [VERT_W-1:0] VERT_ZERO = 8'sd0;

  // Configuration register index
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_HEAD = 1'b0,
    REG_TAIL = 1'b1
  } cfg_reg_t;

  // Speed mode codes
  typedef enum logic [MODE_W-1:0] {
    MODE_NORMAL = 2'd0,
    MODE_FAST   = 2'd1,
    MODE_SLOW   = 2'd2
  } speed_mode_t;

  // Snap the deadband to center, then remove the center offset
  function automatic logic signed [AXIS_W-1:0] axis_offset(input logic [BYTE_W-1:0] b);
    logic [AXIS_W-1:0] ext;
    ext = {1'b0, b};
    if (b >= DEAD_LO && b <= DEAD_HI) begin
      return '0;
    end
    return $signed(ext - CENTER);
  endfunction

  // d * 1024 / 17 rounded: 1024 = 17*60 + 4, so
  // q = 60*mag + floor((4*mag + 8) / 17), the small quotient by reciprocal 241/4096
  function automatic logic signed [PITCH_W-1:0] pitch_scale(input logic signed [AXIS_W-1:0] d);
    logic [AXIS_W-1:0]  dabs;
    logic [7:0]         mag;
    logic [9:0]         rem_num;
    logic [17:0]        rem_prod;
    logic [4:0]         rem_q;
    logic [PITCH_W-1:0] q;
    dabs     = d[AXIS_W-1] ? (~d + 9'd1) : d;
    mag      = dabs[7:0];
    rem_num  = {mag, 2'b00} + 10'd8;
    rem_prod = {8'd0, rem_num} * 18'd241;
    rem_q    = rem_prod[16:12];
    q        = ({6'd0, mag} * 14'd60) + {9'd0, rem_q};
    return d[AXIS_W-1] ? $signed(~q + 14'd1) : $signed(q);
  endfunction

endpackage

/* design/cfdd_stream_if.sv */
// ----------------------------------------------------------------------------
// cfdd_stream_if: received byte channel
// Valid/ready channel carrying one stream byte and its end of buffer mark.
// ----------------------------------------------------------------------------
interface cfdd_stream_if
  import cfdd_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              end_of_buffer;

  modport source (output valid, output data_byte, output end_of_buffer, input ready);
  modport sink   (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

/* design/cfdd_command_if.sv */
// ----------------------------------------------------------------------------
// cfdd_command_if: motion command channel
// Valid/ready channel carrying one decoded motion command.
// ----------------------------------------------------------------------------
interface cfdd_command_if
  import cfdd_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic signed [AXIS_W-1:0]  surge_level;
  logic signed [AXIS_W-1:0]  sway_level;
  logic signed [AXIS_W-1:0]  turn_level;
  logic signed [PITCH_W-1:0] pitch_angle;
  logic signed [VERT_W-1:0]  vertical_thrust;
  logic [MODE_W-1:0]         speed_mode;

  modport source (output valid, output surge_level, output sway_level, output turn_level,
                  output pitch_angle, output vertical_thrust, output speed_mode,
                  input ready);
  modport sink   (input valid, input surge_level, input sway_level, input turn_level,
                  input pitch_angle, input vertical_thrust, input speed_mode,
                  output ready);
endinterface

/* design/control_frame_deframer_deadband_unit.sv */
// ----------------------------------------------------------------------------
// control_frame_deframer_deadband_unit: frame sync and command decode
// A command appears in the cycle after the tail word is accepted.
// Throughput: one word per cycle unless the command is stalled. The window
// check, checksum and pitch scaling sit between window and command register.
// Reset: synchronous; empties the window, drops any held command and loads
// the default head and tail values.
// ----------------------------------------------------------------------------
module control_frame_deframer_deadband_unit
  import cfdd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  cfdd_stream_if.sink            stream,
  cfdd_command_if.source         command
);

  logic [BYTE_W-1:0] head_byte;
  logic [BYTE_W-1:0] tail_byte;
  logic [BYTE_W-1:0] byte_window [WIN_DEPTH];
  logic [FILL_W-1:0] window_fill;
  logic              accept;
  logic              frame_match;
  logic [BYTE_W-1:0] checksum;
  logic [BYTE_W-1:0] buttons;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      head_byte <= HEAD_RESET;
      tail_byte <= TAIL_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_HEAD: head_byte <= cfg_data;
        REG_TAIL: tail_byte <= cfg_data;
        default: ;
      endcase
    end
  end

  // Take a word whenever the command register is free or draining
  assign stream.ready = !command.valid || command.ready;
  assign accept       = stream.valid && stream.ready;

  // Frame check: head at the oldest slot, tail incoming, checksum over payload
  always_comb begin
    checksum = '0;
    for (int i = 1; i <= 6; i++) begin
      checksum = checksum ^ byte_window[i];
    end
    frame_match = (window_fill == FILL_W'(WIN_DEPTH)) &&
                  (byte_window[0] == head_byte) &&
                  (stream.data_byte == tail_byte) &&
                  (checksum == byte_window[WIN_DEPTH-1]);
  end

  assign buttons = byte_window[5];

  // Advance the window; clear it on a frame or at end of buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      window_fill <= '0;
    end else if (accept) begin
      if (frame_match || stream.end_of_buffer) begin
        window_fill <= '0;
      end else if (window_fill != FILL_W'(WIN_DEPTH)) begin
        window_fill <= window_fill + FILL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < WIN_DEPTH - 1; i++) begin
        byte_window[i] <= byte_window[i+1];
      end
      byte_window[WIN_DEPTH-1] <= stream.data_byte;
    end
  end

  // Command valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      command.valid <= 1'b0;
    end else if (accept && frame_match) begin
      command.valid <= 1'b1;
    end else if (command.ready) begin
      command.valid <= 1'b0;
    end
  end

  // Decode the frame into the command register
  always_ff @(posedge clk) begin
    if (accept && frame_match) begin
      command.surge_level <= axis_offset(byte_window[1]);
      command.sway_level  <= axis_offset(byte_window[2]);
      command.turn_level  <= axis_offset(byte_window[3]);
      command.pitch_angle <= pitch_scale(axis_offset(byte_window[4]));
      if (buttons[BTN_UP]) begin
        command.vertical_thrust <= VERT_POS;
      end else if (buttons[BTN_DOWN]) begin
        command.vertical_thrust <= VERT_NEG;
      end else begin
        command.vertical_thrust <= VERT_ZERO;
      end
      if (buttons[BTN_SLOW]) begin
        command.speed_mode <= MODE_SLOW;
      end else if (buttons[BTN_FAST]) begin
        command.speed_mode <= MODE_FAST;
      end else begin
        command.speed_mode <= MODE_NORMAL;
      end
    end
  end

endmodule

/* tb/sv/tb_control_frame_deframer_deadband_unit.sv */
// ----------------------------------------------------------------------------
// tb_control_frame_deframer_deadband_unit: frame sync and command decode test
// Streams bytes into the deframer, predicts random-frame commands from a
// local copy of the byte window and frame marks, and compares each command
// field by field. A short directed table with its own expected commands
// opens the run. Random frames, broken frames and noise follow under several
// head/tail settings, with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_control_frame_deframer_deadband_unit;
  import cfdd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [AXIS_W-1:0]  x;
    logic signed [AXIS_W-1:0]  y;
    logic signed [AXIS_W-1:0]  yaw;
    logic signed [PITCH_W-1:0] pitch;
    logic signed [VERT_W-1:0]  vert;
    speed_mode_t               mode;
  } motion_cmd_t;

  typedef struct {
    logic [BYTE_W-1:0] data;
    logic              eob;
    bit                typed;
    int                x;
    int                y;
    int                yaw;
    int                pitch;
    int                vert;
    speed_mode_t       mode;
  } directed_row_t;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  cfdd_stream_if  stream_ch ();
  cfdd_command_if command_ch ();

  control_frame_deframer_deadband_unit uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .stream    (stream_ch),
    .command   (command_ch)
  );

  always #5 clk = ~clk;

  // Predictor state: frame marks and the last eight stream bytes
  logic [BYTE_W-1:0] head_mark;
  logic [BYTE_W-1:0] tail_mark;
  logic [BYTE_W-1:0] recent_bytes [WIN_DEPTH];
  int unsigned       recent_count;

  motion_cmd_t expected_commands [$];
  int unsigned mismatches = 0;
  bit          quiet_run = 1'b0;
  int unsigned stall_left = 0;

  // Directed frames: two good frames with extreme and deadband axes, the
  // second closing a buffer, then a frame whose check byte is off by one bit
  directed_row_t directed_rows [27] = '{
    '{8'd170, 1'b0, 1'b0, 0, 0, 0, 0, 0, MODE_NORMAL},
    '{8'd0,   1'b0, 1'b0, 0, 0, 0, 0, 0, MODE_NORMAL},
    '{8'd255, 1'b0, 1'b0, 0, 0, 0, 0, 0, MODE_NORMAL},
    '{8'd123, 1'b0, 1'b0, 0, 0, 0, 0, 0, MODE_NORMAL},
    '{8'd0,   1'b0, 1'b0, 0, 0, 0, 0, 0, MODE_NORMAL},
    '{8'h0A,  1'b0, 1'b0, 0, 0, 0, 0, 0, MODE_NORMAL},
    '{8'h5A,  1'b0, 1'b0, 0, 0, 0, 0, 0, MODE_NORMAL},
    '{8'hD4,  1'b0, 1'b0, 0, 0, 0, 0, 0, MODE_NORMAL},
    '{8'd85,  1'b0, 1'b1, -127, 128, 0, -7650, 64, MODE_SLOW},
    '{8'd170, 1'b0, 1'b0, 0, 0, 0, 0, 0, MODE_NORMAL},
    '{8'd131, 1'b0, 1'b0, 0, 0, 0, 0, 0, MODE_NORMAL},
    '{8'd122, 1'b0, 1'b0, 0, 0, 0, 0, 0, MODE_NORMAL},
    '{8'd132, 1'b0, 1'b0, 0, 0, 0, 0, 0, MODE_NORMAL},
    '{8'd255, 1'b0, 1'b0, 0, 0, 0, 0, 0, MODE_NORMAL},
    '{8'h05,  1'b0, 1'b0, 0, 0, 0, 0, 0, MODE_NORMAL},
    '{8'h00,  1'b0, 1'b0, 0, 0, 0, 0, 0, MODE_NORMAL},
    '{8'h87,  1'b0, 1'b0, 0, 0, 0, 0, 0, MODE_NORMAL},
    '{8'd85,  1'b1, 1'b1, 0, -5, 5, 7710, -64, MODE_FAST},
    '{8'd170, 1'b0, 1'b0, 0, 0, 0, 0, 0, MODE_NORMAL},
    '{8'd0,   1'b0, 1'b0, 0, 0, 0, 0, 0, MODE_NORMAL},
    '{8'd255, 1'b0, 1'b0, 0, 0, 0, 0, 0, MODE_NORMAL},
    '{8'd123, 1'b0, 1'b0, 0, 0, 0, 0, 0, MODE_NORMAL},
    '{8'd0,   1'b0, 1'b0, 0, 0, 0, 0, 0, MODE_NORMAL},
    '{8'h0A,  1'b0, 1'b0, 0, 0, 0, 0, 0, MODE_NORMAL},
    '{8'h5A,  1'b0, 1'b0, 0, 0, 0, 0, 0, MODE_NORMAL},
    '{8'hD5,  1'b0, 1'b0, 0, 0, 0, 0, 0, MODE_NORMAL},
    '{8'd85,  1'b0, 1'b0, 0, 0, 0, 0, 0, MODE_NORMAL}
  };

  // Empty the predicted window
  function automatic void flush_recent();
    for (int i = 0; i < WIN_DEPTH; i++) begin
      recent_bytes[i] = '0;
    end
    recent_count = 0;
  endfunction

  // Snap the deadband to center and take the offset from center
  function automatic int stick_offset(input logic [BYTE_W-1:0] b);
    int v;
    v = (b >= DEAD_LO && b <= DEAD_HI) ? 127 : int'(b);
    return v - 127;
  endfunction

  // Pitch in 1/256 degree: round |d| * 1024 / 17, then restore the sign
  function automatic int pitch_256ths(input int d);
    int mag;
    int q;
    mag = (d < 0) ? -d : d;
    q = (mag * 1024 + 8) / 17;
    return (d < 0) ? -q : q;
  endfunction

  // Advance the predicted window by one word; return 1 when a frame closes
  function automatic bit predict_command(input logic [BYTE_W-1:0] b, input logic eob,
                                         output motion_cmd_t cmd);
    logic [BYTE_W-1:0] parity;
    logic [BYTE_W-1:0] btn;
    bit                hit;
    hit = 1'b0;
    if (recent_count >= WIN_DEPTH && recent_bytes[0] == head_mark && b == tail_mark) begin
      parity = '0;
      for (int i = 1; i <= 6; i++) begin
        parity ^= recent_bytes[i];
      end
      hit = (parity == recent_bytes[7]);
    end
    if (hit) begin
      btn = recent_bytes[5];
      cmd.x = stick_offset(recent_bytes[1]);
      cmd.y = stick_offset(recent_bytes[2]);
      cmd.yaw = stick_offset(recent_bytes[3]);
      cmd.pitch = pitch_256ths(stick_offset(recent_bytes[4]));
      cmd.vert = btn[BTN_UP] ? VERT_POS : (btn[BTN_DOWN] ? VERT_NEG : VERT_ZERO);
      cmd.mode = btn[BTN_SLOW] ? MODE_SLOW : (btn[BTN_FAST] ? MODE_FAST : MODE_NORMAL);
      flush_recent();
    end else begin
      for (int i = 0; i < WIN_DEPTH - 1; i++) begin
        recent_bytes[i] = recent_bytes[i + 1];
      end
      recent_bytes[WIN_DEPTH - 1] = b;
      if (recent_count < WIN_DEPTH) begin
        recent_count++;
      end
    end
    if (eob) begin
      flush_recent();
    end
    return hit;
  endfunction

  function automatic void check_field(input string name, input logic signed [31:0] want,
                                      input logic signed [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Send one word, with an optional idle burst first; predict on acceptance
  task automatic send_word(input logic [BYTE_W-1:0] data, input logic eob,
                           input bit typed, input motion_cmd_t typed_cmd);
    motion_cmd_t cmd;
    bit          hit;
    if (!quiet_run && $urandom_range(0, 5) == 0) begin
      stream_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    stream_ch.valid         <= 1'b1;
    stream_ch.data_byte     <= data;
    stream_ch.end_of_buffer <= eob;
    @(posedge clk);
    while (!stream_ch.ready) @(posedge clk);
    hit = predict_command(data, eob, cmd);
    if (typed) begin
      expected_commands.push_back(typed_cmd);
    end else if (hit) begin
      expected_commands.push_back(cmd);
    end
  endtask

  // Hold the stream until every expected command has come out
  task automatic drain_commands();
    stream_ch.valid <= 1'b0;
    while (expected_commands.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Load both frame marks on consecutive edges
  task automatic load_frame_marks(input logic [BYTE_W-1:0] head, input logic [BYTE_W-1:0] tail);
    cfg_we    <= 1'b1;
    cfg_index <= REG_HEAD;
    cfg_data  <= head;
    @(posedge clk);
    head_mark = head;
    cfg_index <= REG_TAIL;
    cfg_data  <= tail;
    @(posedge clk);
    tail_mark = tail;
    cfg_we <= 1'b0;
  endtask

  // Axis bytes lean toward the deadband edges and the stick extremes
  function automatic logic [BYTE_W-1:0] pick_axis_byte();
    case ($urandom_range(0, 5))
      0: return 8'($urandom_range(120, 134));
      1: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      default: return 8'($urandom);
    endcase
  endfunction

  // Mostly good frames with random content, some broken ones, some noise
  task automatic send_random(input int unsigned n_words);
    int unsigned       sent;
    int unsigned       kind;
    int unsigned       len;
    logic [BYTE_W-1:0] frame [9];
    logic              eob;
    motion_cmd_t       no_cmd;
    sent = 0;
    while (sent < n_words) begin
      kind = $urandom_range(0, 9);
      if (kind == 9) begin
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++) begin
          frame[i] = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom);
        end
      end else begin
        len = 9;
        frame[0] = head_mark;
        for (int i = 1; i <= 4; i++) begin
          frame[i] = pick_axis_byte();
        end
        frame[5] = 8'($urandom);
        frame[6] = 8'($urandom);
        frame[7] = frame[1] ^ frame[2] ^ frame[3] ^ frame[4] ^ frame[5] ^ frame[6];
        frame[8] = tail_mark;
        if (kind == 7) begin
          frame[7] ^= 8'($urandom_range(1, 255));
        end else if (kind == 8) begin
          frame[8] ^= 8'($urandom_range(1, 255));
        end
      end
      for (int i = 0; i < len; i++) begin
        eob = ($urandom_range(0, 39) == 0) || (i == 8 && $urandom_range(0, 5) == 0);
        send_word(frame[i], eob, 1'b0, no_cmd);
      end
      sent += len;
    end
  endtask

  // Command sink: stall in random bursts unless the run is in its quiet part
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      command_ch.ready <= 1'b0;
    end else if (!quiet_run && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 8);
      command_ch.ready <= 1'b0;
    end else begin
      command_ch.ready <= 1'b1;
    end
  end

  // Compare each accepted command with the oldest prediction
  always @(posedge clk) begin
    motion_cmd_t want;
    if (!rst && command_ch.valid && command_ch.ready) begin
      if (expected_commands.size() == 0) begin
        $display("%0t: command with none expected: surge %0d sway %0d turn %0d pitch %0d",
                 $time, command_ch.surge_level, command_ch.sway_level,
                 command_ch.turn_level, command_ch.pitch_angle);
        mismatches++;
      end else begin
        want = expected_commands.pop_front();
        check_field("surge_level", want.x, command_ch.surge_level);
        check_field("sway_level", want.y, command_ch.sway_level);
        check_field("turn_level", want.yaw, command_ch.turn_level);
        check_field("pitch_angle", want.pitch, command_ch.pitch_angle);
        check_field("vertical_thrust", want.vert, command_ch.vertical_thrust);
        check_field("speed_mode", want.mode, command_ch.speed_mode);
      end
    end
  end

  // Main sequence
  initial begin
    motion_cmd_t row_cmd;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_HEAD;
    cfg_data = '0;
    stream_ch.valid = 1'b0;
    stream_ch.data_byte = '0;
    stream_ch.end_of_buffer = 1'b0;
    command_ch.ready = 1'b0;
    head_mark = HEAD_RESET;
    tail_mark = TAIL_RESET;
    flush_recent();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed table under the reset frame marks
    foreach (directed_rows[i]) begin
      row_cmd.x = directed_rows[i].x;
      row_cmd.y = directed_rows[i].y;
      row_cmd.yaw = directed_rows[i].yaw;
      row_cmd.pitch = directed_rows[i].pitch;
      row_cmd.vert = directed_rows[i].vert;
      row_cmd.mode = directed_rows[i].mode;
      send_word(directed_rows[i].data, directed_rows[i].eob, directed_rows[i].typed, row_cmd);
    end
    send_random(300);
    drain_commands();

    // Frame mark extremes, a random pair, then back to the defaults
    load_frame_marks(8'h00, 8'h00);
    send_random(250);
    drain_commands();
    load_frame_marks(8'hFF, 8'hFF);
    send_random(250);
    drain_commands();
    load_frame_marks(8'($urandom), 8'($urandom));
    send_random(250);
    drain_commands();
    load_frame_marks(HEAD_RESET, TAIL_RESET);
    send_random(150);
    quiet_run = 1'b1;
    send_random(100);

    drain_commands();
    repeat (5) @(posedge clk);
    if (mismatches == 0) begin
      $display("[control_frame_deframer_deadband_unit] OK");
    end else begin
      $display("[control_frame_deframer_deadband_unit] ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("[control_frame_deframer_deadband_unit] ERROR");
    $finish;
  end

endmodule

/* control_frame_deframer_deadband_unit.f */
design/cfdd_pkg.sv
design/cfdd_stream_if.sv
design/cfdd_command_if.sv
design/control_frame_deframer_deadband_unit.sv
tb/sv/tb_control_frame_deframer_deadband_unit.sv
